// File: hw/rtl/card_deck_shuffle_dealer_core_macros.svh
// Assertion macros shared by the card deck dealer RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef CARD_DECK_SHUFFLE_DEALER_CORE_MACROS_SVH
`define CARD_DECK_SHUFFLE_DEALER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CDSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CDSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cdsd_pkg.sv
// Package for the card deck shuffle dealer: sizes, command and status codes,
// and the request/response types of the shared remainder unit. No dependencies.
`timescale 1ns / 1ps

package cdsd_pkg;

  // Deck geometry
  localparam int DECK_SIZE = 52;
  localparam int IDX_W     = $clog2(DECK_SIZE);
  localparam int CNT_W     = $clog2(DECK_SIZE + 1);

  // Port field widths
  localparam int CMD_W    = 2;
  localparam int RND_W    = 32;
  localparam int CARD_W   = 6;
  localparam int STATUS_W = 2;
  localparam int LEFT_W   = 6;
  localparam int STEP_W   = $clog2(RND_W);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_REFILL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWAP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEAL   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SWAP_IGN = 2'd2;

  // Remainder unit request and response
  typedef struct packed {
    logic             go;
    logic [RND_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

endpackage

// File: hw/rtl/cdsd_mod_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on cdsd_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module cdsd_mod_unit import cdsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RND_W - 1);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [RND_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  rem_nxt;

  // Shared compare/subtract step
  always_comb begin
    trial = {rem_r, dvd_r[RND_W-1]};
    diff  = trial - {1'b0, dsr_r};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = diff[CNT_W-1:0];
    end else begin
      rem_nxt = trial[CNT_W-1:0];
    end
  end

  // Control: run for RND_W steps, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// File: hw/rtl/card_deck_shuffle_dealer_core.sv
// Card deck shuffle dealer: refill, one Fisher-Yates swap per request, deal.
// Steps: refill completes on acceptance; deal reads the deck, then strobes; swap
// runs the bit-serial remainder unit, one read of both entries and two writes.
// No new request is taken while busy; busy drops in the strobe cycle.
// Synchronous active-low reset restores identity order and full counts.
// Depends on cdsd_pkg, cdsd_mod_unit and the assertion macro header.
`timescale 1ns / 1ps
`include "card_deck_shuffle_dealer_core_macros.svh"

module card_deck_shuffle_dealer_core import cdsd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [RND_W-1:0]    in_random_word,
  output logic                out_valid,
  output logic [CARD_W-1:0]   out_card,
  output logic [STATUS_W-1:0] out_status,
  output logic [LEFT_W-1:0]   out_cards_left,
  output logic                out_shuffle_done
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SWRD  = 3'd2;
  localparam logic [2:0] S_SWA   = 3'd3;
  localparam logic [2:0] S_SWB   = 3'd4;
  localparam logic [2:0] S_DLRD  = 3'd5;
  localparam logic [2:0] S_DLOUT = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic [IDX_W-1:0]    b_r, b_nxt;

  logic                out_valid_r;
  logic [CARD_W-1:0]   out_card_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [LEFT_W-1:0]   out_left_r;
  logic                out_done_r;

  logic                accept;
  logic                emit;
  logic [IDX_W-1:0]    card_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic                refill;

  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  // Deck memory and per-entry written flags (unwritten entry reads as its index)
  logic [IDX_W-1:0]     deck_mem [DECK_SIZE];
  logic [DECK_SIZE-1:0] wvld_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr_a, rd_addr_b;
  logic [IDX_W-1:0]     rd_a_r, rd_b_r;
  logic                 vld_a_r, vld_b_r;
  logic [IDX_W-1:0]     addr_a_r, addr_b_r;
  logic [IDX_W-1:0]     val_a, val_b;
  logic                 we;
  logic [IDX_W-1:0]     wr_addr, wr_data;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign val_a  = vld_a_r ? rd_a_r : addr_a_r;
  assign val_b  = vld_b_r ? rd_b_r : addr_b_r;

  // Shared remainder unit
  cdsd_mod_unit u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mod_req),
    .rsp  (mod_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    pos_nxt          = pos_r;
    left_nxt         = left_r;
    b_nxt            = b_r;
    emit             = 1'b0;
    card_nxt         = '0;
    status_nxt       = ST_OK;
    refill           = 1'b0;
    mod_req.go       = 1'b0;
    mod_req.dividend = in_random_word;
    mod_req.divisor  = pos_r;
    rd_en            = 1'b0;
    rd_addr_a        = IDX_W'(pos_r - CNT_W'(1));
    rd_addr_b        = b_r;
    we               = 1'b0;
    wr_addr          = addr_a_r;
    wr_data          = val_b;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_REFILL: begin
              refill   = 1'b1;
              pos_nxt  = CNT_W'(DECK_SIZE);
              left_nxt = CNT_W'(DECK_SIZE);
              emit     = 1'b1;
            end
            CMD_SWAP: begin
              if (pos_r > CNT_W'(1)) begin
                mod_req.go = 1'b1;
                state_nxt  = S_DIV;
              end else begin
                status_nxt = ST_SWAP_IGN;
                emit       = 1'b1;
              end
            end
            CMD_DEAL: begin
              if (left_r == '0) begin
                status_nxt = ST_EMPTY;
                emit       = 1'b1;
              end else begin
                state_nxt = S_DLRD;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_DIV: begin
        if (mod_rsp.done) begin
          b_nxt     = IDX_W'(mod_rsp.rem);
          state_nxt = S_SWRD;
        end
      end
      S_SWRD: begin
        rd_en     = 1'b1;
        state_nxt = S_SWA;
      end
      S_SWA: begin
        we        = 1'b1;
        state_nxt = S_SWB;
      end
      S_SWB: begin
        we        = 1'b1;
        wr_addr   = addr_b_r;
        wr_data   = val_a;
        pos_nxt   = pos_r - CNT_W'(1);
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DLRD: begin
        rd_en     = 1'b1;
        rd_addr_a = IDX_W'(left_r - CNT_W'(1));
        state_nxt = S_DLOUT;
      end
      S_DLOUT: begin
        card_nxt  = val_a;
        left_nxt  = left_r - CNT_W'(1);
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= CNT_W'(DECK_SIZE);
      left_r      <= CNT_W'(DECK_SIZE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      left_r      <= left_nxt;
      out_valid_r <= emit;
    end
  end

  // Result payload and swap target
  always_ff @(posedge clk) begin
    b_r <= b_nxt;
    if (emit) begin
      out_card_r   <= CARD_W'(card_nxt);
      out_status_r <= status_nxt;
      out_left_r   <= LEFT_W'(left_nxt);
      out_done_r   <= (pos_nxt <= CNT_W'(1));
    end
  end

  // Written flags: cleared by reset and refill
  always_ff @(posedge clk) begin
    if (!rst_n || refill) begin
      wvld_r <= '0;
    end else if (we) begin
      wvld_r[wr_addr] <= 1'b1;
    end
  end

  // Deck memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      deck_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r   <= deck_mem[rd_addr_a];
      rd_b_r   <= deck_mem[rd_addr_b];
      vld_a_r  <= wvld_r[rd_addr_a];
      vld_b_r  <= wvld_r[rd_addr_b];
      addr_a_r <= rd_addr_a;
      addr_b_r <= rd_addr_b;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_card         = out_card_r;
  assign out_status       = out_status_r;
  assign out_cards_left   = out_left_r;
  assign out_shuffle_done = out_done_r;

  // Checks
  `CDSD_ASSERT_IMP(a_out_in_idle, out_valid_r, state_r == S_IDLE, "result strobe outside idle")
  `CDSD_ASSERT_NXT(a_accept_progress, accept, out_valid_r || state_r != S_IDLE, "request dropped")
  `CDSD_ASSERT_IMP(a_div_done_state, mod_rsp.done, state_r == S_DIV, "stray remainder done")
  `CDSD_ASSERT_NXT(a_pos_step, state_r == S_SWB, pos_r == $past(pos_r) - CNT_W'(1), "bad pos step")

endmodule
